FILE: sv/efla_pkg.sv
package efla_pkg;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_FREE_DEC,
    S_SHR_RD,
    S_SHR_WR,
    S_INS_WR,
    S_DROP_RD,
    S_DROP_WR,
    S_MRG_BOTH,
    S_MRG_BOTH_WR,
    S_MRG_RIGHT,
    S_MRG_LEFT,
    S_UPD_WR,
    S_DONE
  } state_e;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FieldW  = 32;

endpackage

FILE: sv/efla_if.sv
interface efla_req_if;
  import efla_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [FieldW-1:0] range_start;
  logic [FieldW-1:0] range_end;
  logic [FieldW-1:0] request_size;
  modport source (output valid, mode, range_start, range_end, request_size, input ready);
  modport sink   (input valid, mode, range_start, range_end, request_size, output ready);
endinterface

interface efla_rsp_if;
  import efla_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [FieldW-1:0]  location;
  modport source (output valid, status, location, input ready);
  modport sink   (input valid, status, location, output ready);
endinterface

FILE: sv/efla_ram.sv
module efla_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/extent_free_list_allocator.sv
// First-fit extent allocator with coalescing. Keeps an address-ordered table of
// free inclusive extents in one synchronous ram (first and last bound per entry).
// Each request (free, alloc, clear) gives exactly one response. A request runs
// as a scan over the table, each entry read as an address and then its registered
// data, then, if entries must move, a shift pass that reads and writes each moved
// entry. A clear, an unused mode or a free with a reversed range goes straight from
// the taken request to S_DONE, which raises the response. The ram port is the
// limit: one read and one write per cycle. The response sits in an output register,
// and the next request is taken the cycle after it has been delivered.
module extent_free_list_allocator
  import efla_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 16,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  efla_req_if.sink   req_i,
  efla_rsp_if.source rsp_o
);
  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned RamW = 2 * ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] AddrMax = '1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_EXTENTS);

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  // scan index, wide enough to hold count
  logic [CntW-1:0] pos_q, pos_d;
  // shift pointer
  logic [CntW-1:0] k_q, k_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [ADDR_BITS-1:0] s_q, s_d, e_q, e_d, size_q, size_d;
  // last bound of the entry before pos
  logic [ADDR_BITS-1:0] prev_last_q, prev_last_d;
  logic [ADDR_BITS-1:0] hold_q, hold_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [FieldW-1:0] loc_q, loc_d;
  logic rsp_valid_q, rsp_valid_d;

  // ram port
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [RamW-1:0]  wdata, rdata;
  logic [ADDR_BITS-1:0] rd_first, rd_last;

  assign rd_first = rdata[RamW-1:ADDR_BITS];
  assign rd_last  = rdata[ADDR_BITS-1:0];

  efla_ram #(.Width(RamW), .Depth(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready    = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.location = loc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    k_q         <= k_d;
    mode_q      <= mode_d;
    s_q         <= s_d;
    e_q         <= e_d;
    size_q      <= size_d;
    prev_last_q <= prev_last_d;
    hold_q      <= hold_d;
    status_q    <= status_d;
    loc_q       <= loc_d;
  end

  logic left_m, right_m;
  logic [ADDR_BITS-1:0] span, sz_m1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    k_d         = k_q;
    mode_d      = mode_q;
    s_d         = s_q;
    e_d         = e_q;
    size_d      = size_q;
    prev_last_d = prev_last_q;
    hold_d      = hold_q;
    status_d    = status_q;
    loc_d       = loc_q;
    rsp_valid_d = rsp_valid_q;
    we          = 1'b0;
    waddr       = pos_q[IdxW-1:0];
    wdata       = {s_q, e_q};
    raddr       = pos_q[IdxW-1:0];
    span        = rd_last - rd_first;
    sz_m1       = size_q - ADDR_BITS'(1);
    left_m      = (pos_q != '0) && (prev_last_q != AddrMax)
                  && (prev_last_q + ADDR_BITS'(1) == s_q);
    right_m     = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          mode_d   = req_i.mode;
          s_d      = ADDR_BITS'(req_i.range_start);
          e_d      = ADDR_BITS'(req_i.range_end);
          size_d   = ADDR_BITS'(req_i.request_size);
          pos_d    = '0;
          status_d = ST_OK;
          loc_d    = '0;
          state_d  = S_RD;
          case (mode_e'(req_i.mode))
            MODE_FREE: begin
              if (ADDR_BITS'(req_i.range_end) < ADDR_BITS'(req_i.range_start)) begin
                status_d = ST_OVERLAP;
                state_d  = S_DONE;
              end
            end
            MODE_ALLOC: ;
            MODE_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // issue read of entry pos
      S_RD: begin
        raddr = pos_q[IdxW-1:0];
        if (pos_q >= count_q) begin
          if (mode_q == MODE_ALLOC) begin
            status_d = ST_NOFIT;
            state_d  = S_DONE;
          end else begin
            state_d = S_FREE_DEC;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      // entry pos is on rdata
      S_SCAN: begin
        if (mode_q == MODE_ALLOC) begin
          if (size_q == '0) begin
            loc_d   = FieldW'(rd_first);
            state_d = S_DONE;
          end else if (sz_m1 <= span) begin
            loc_d = FieldW'(rd_first);
            if (sz_m1 == span) begin
              k_d     = pos_q;
              state_d = S_DROP_RD;
            end else begin
              s_d     = rd_first + size_q;
              e_d     = rd_last;
              state_d = S_UPD_WR;
            end
          end else begin
            pos_d   = pos_q + CntW'(1);
            state_d = S_RD;
          end
        end else if (rd_first <= e_q) begin
          if (rd_last >= s_q) begin
            status_d = ST_OVERLAP;
            state_d  = S_DONE;
          end else begin
            prev_last_d = rd_last;
            pos_d       = pos_q + CntW'(1);
            state_d     = S_RD;
          end
        end else begin
          // stopped before entry pos, whose bounds are in hand
          hold_d  = rd_first;
          state_d = S_FREE_DEC;
        end
      end
      S_FREE_DEC: begin
        right_m = (pos_q < count_q) && (e_q != AddrMax)
                  && (e_q + ADDR_BITS'(1) == hold_q);
        if (left_m && right_m) begin
          // read entry pos to take its last bound
          raddr   = pos_q[IdxW-1:0];
          state_d = S_MRG_BOTH;
        end else if (left_m) begin
          // previous entry grows up to e, read it for its first bound
          raddr   = IdxW'(pos_q - CntW'(1));
          state_d = S_MRG_LEFT;
        end else if (right_m) begin
          raddr   = pos_q[IdxW-1:0];
          state_d = S_MRG_RIGHT;
        end else if (count_q >= CntMax) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          k_d     = count_q;
          state_d = (count_q == pos_q) ? S_INS_WR : S_SHR_RD;
        end
      end
      // both sides: keep last bound of entry pos, read the previous entry
      S_MRG_BOTH: begin
        e_d     = rd_last;
        raddr   = IdxW'(pos_q - CntW'(1));
        state_d = S_MRG_BOTH_WR;
      end
      // previous entry spans up to the end of entry pos, then drop pos
      S_MRG_BOTH_WR: begin
        we      = 1'b1;
        waddr   = IdxW'(pos_q - CntW'(1));
        wdata   = {rd_first, e_q};
        k_d     = pos_q;
        state_d = S_DROP_RD;
      end
      S_MRG_RIGHT: begin
        we      = 1'b1;
        waddr   = pos_q[IdxW-1:0];
        wdata   = {s_q, rd_last};
        state_d = S_DONE;
      end
      S_MRG_LEFT: begin
        we      = 1'b1;
        waddr   = IdxW'(pos_q - CntW'(1));
        wdata   = {rd_first, e_q};
        state_d = S_DONE;
      end
      // shift right: entry k-1 moves to k, from count down to pos+1
      S_SHR_RD: begin
        raddr   = IdxW'(k_q - CntW'(1));
        state_d = S_SHR_WR;
      end
      S_SHR_WR: begin
        we      = 1'b1;
        waddr   = k_q[IdxW-1:0];
        wdata   = rdata;
        k_d     = k_q - CntW'(1);
        state_d = ((k_q - CntW'(1)) == pos_q) ? S_INS_WR : S_SHR_RD;
      end
      S_INS_WR: begin
        we      = 1'b1;
        waddr   = pos_q[IdxW-1:0];
        wdata   = {s_q, e_q};
        count_d = count_q + CntW'(1);
        state_d = S_DONE;
      end
      // drop entry k: entry k+1 moves to k until the end
      S_DROP_RD: begin
        raddr = IdxW'(k_q + CntW'(1));
        if (k_q + CntW'(1) >= count_q) begin
          count_d = count_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        we      = 1'b1;
        waddr   = k_q[IdxW-1:0];
        wdata   = rdata;
        k_d     = k_q + CntW'(1);
        state_d = S_DROP_RD;
      end
      S_UPD_WR: begin
        we      = 1'b1;
        waddr   = pos_q[IdxW-1:0];
        wdata   = {s_q, e_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("extent count exceeds capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready) else $error("request taken while busy");
  a_rsp_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> rsp_valid_q) else $error("response not raised");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow table");
`endif
endmodule
